### rtl/core/qkr_pkg.sv
// Package for the keyed-remove FIFO queue: sizes, operation and status codes,
// and the controller-to-datapath command type. No dependencies.
package qkr_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ITEM_BITS   = 8;
   localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_ENQ = 2'd0;
   localparam logic [1:0] OP_DEQ = 2'd1;
   localparam logic [1:0] OP_REM = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic load;
      logic exec;
   } qkr_cmd_type;

endpackage

### rtl/core/qkr_controller.sv
// Sequencer for the keyed-remove FIFO queue: accepts an item, runs the
// execute step and owns the result valid flag. Depends on qkr_pkg.
module qkr_controller import qkr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output qkr_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      req_stall    = (state_ff != S_IDLE);
      cmd.load     = (state_ff == S_IDLE) && req_valid;
      cmd.exec     = (state_ff == S_EXEC) && out_free;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/core/qkr_datapath.sv
// Datapath of the keyed-remove FIFO queue: entry cells with head at cell 0,
// parallel key compare, gap closing shift and result registers. Depends on qkr_pkg.
module qkr_datapath import qkr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  qkr_cmd_type          cmd,
   input  logic [1:0]           req_op,
   input  logic [ITEM_BITS-1:0] req_item,
   output logic [ITEM_BITS-1:0] rsp_item_out,
   output logic [1:0]           rsp_status,
   output logic                 rsp_empty_res
);

   logic [ITEM_BITS-1:0]   entry_ff [QUEUE_DEPTH];
   logic [ITEM_BITS-1:0]   entry_in [QUEUE_DEPTH];
   logic [OCC_BITS-1:0]    occ_ff, occ_in;
   logic [1:0]             op_ff;
   logic [ITEM_BITS-1:0]   item_ff;
   logic [QUEUE_DEPTH-1:0] match_ff, match_in;
   logic [ITEM_BITS-1:0]   res_item_ff, res_item_in;
   logic [1:0]             status_ff, status_in;
   logic                   empty_ff, empty_in;

   logic [QUEUE_DEPTH-1:0] pick, shift_mask;
   logic                   enq, del, full;

   always_comb begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         match_in[k] = (occ_ff > OCC_BITS'(k)) && (entry_ff[k] == req_item);
      end

      full      = (occ_ff == OCC_BITS'(QUEUE_DEPTH));
      enq       = 1'b0;
      pick      = '0;
      status_in = ST_OK;
      case (op_ff)
         OP_ENQ: begin
            if (full) status_in = ST_FULL;
            else      enq       = 1'b1;
         end
         OP_DEQ: begin
            if (occ_ff == '0) status_in = ST_MISS;
            else              pick      = QUEUE_DEPTH'(1);
         end
         OP_REM: begin
            if (match_ff == '0) status_in = ST_MISS;
            else                pick      = match_ff & (~match_ff + QUEUE_DEPTH'(1));
         end
         default: ;
      endcase

      del        = (pick != '0);
      shift_mask = del ? ~(pick - QUEUE_DEPTH'(1)) : '0;

      res_item_in = '0;
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if (pick[k]) res_item_in = res_item_in | entry_ff[k];
      end

      if (enq)      occ_in = occ_ff + OCC_BITS'(1);
      else if (del) occ_in = occ_ff - OCC_BITS'(1);
      else          occ_in = occ_ff;
      empty_in = (occ_in == '0);

      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         entry_in[k] = entry_ff[k];
         if (enq && (occ_ff == OCC_BITS'(k))) entry_in[k] = item_ff;
      end
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
         if (shift_mask[k]) entry_in[k] = entry_ff[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd.exec) begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         item_ff  <= req_item;
         match_ff <= match_in;
      end
      if (cmd.exec) begin
         for (int k = 0; k < QUEUE_DEPTH; k++) entry_ff[k] <= entry_in[k];
         res_item_ff <= res_item_in;
         status_ff   <= status_in;
         empty_ff    <= empty_in;
      end
   end

   assign rsp_item_out  = res_item_ff;
   assign rsp_status    = status_ff;
   assign rsp_empty_res = empty_ff;

endmodule

### rtl/core/fifo_queue_with_keyed_remove.sv
// Top level of the keyed-remove FIFO queue: controller plus datapath.
// Depends on qkr_pkg, qkr_controller and qkr_datapath.
//
// Ordered queue of handles with enqueue at the tail, dequeue from the head and
// removal of the first entry matching a handle; later entries close the gap in
// the same step. Each item has an accept step, then an execute step. The accept
// step registers the item and compares the handle with every occupied cell at
// once; the execute step picks the first match, shifts the cells and loads the
// result register. Exactly one result per item. A new item can be taken once
// the previous result is produced, while that result may still be waiting; a
// stalled result holds the execute step. In the datapath, only occupancy resets.
module fifo_queue_with_keyed_remove import qkr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [ITEM_BITS-1:0] req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ITEM_BITS-1:0] rsp_item_out,
   output logic [1:0]           rsp_status,
   output logic                 rsp_empty_res
);

   qkr_cmd_type cmd;

   qkr_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   qkr_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_op        (req_op),
      .req_item      (req_item),
      .rsp_item_out  (rsp_item_out),
      .rsp_status    (rsp_status),
      .rsp_empty_res (rsp_empty_res)
   );

endmodule

### rtl/core/qkr_checker.sv
// Port-level checks for the keyed-remove FIFO queue, bound to the top level.
// Depends on qkr_pkg and fifo_queue_with_keyed_remove.
module qkr_checker import qkr_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [ITEM_BITS-1:0] rsp_item_out,
   input logic [1:0]           rsp_status,
   input logic                 rsp_empty_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item_out)
         && $stable(rsp_status) && $stable(rsp_empty_res))
      else $error("stalled result changed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while one is executing");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> !rsp_empty_res)
      else $error("full status with empty queue");

   a_fail_no_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ST_MISS) || (rsp_status == ST_FULL))
         |-> (rsp_item_out == '0))
      else $error("failed operation returned a handle");

endmodule

bind fifo_queue_with_keyed_remove qkr_checker u_qkr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_item_out  (rsp_item_out),
   .rsp_status    (rsp_status),
   .rsp_empty_res (rsp_empty_res)
);
